>>> rtl/lsou_pkg.sv
// shared types and constants of the lifo stack opcode unit
`timescale 1ns / 1ps
package lsou_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;

  // request opcodes carried on in_tuser
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_DUMP = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
  localparam logic [OP_W-1:0] OP_POP  = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 3'd4;

  // what a stack cell loads in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_ABOVE,
    CELL_FROM_BELOW,
    CELL_FROM_WRAP
  } cell_cmd_t;

  typedef logic signed [DATA_W-1:0] entry_t;

endpackage

>>> rtl/lifo_stack_opcode_unit.sv
// lifo stack opcode unit: top level with cell chain and request control
//
// Usage: one request enters on the in_ stream (in_tuser = opcode, in_tdata =
// push value) and its results leave on the out_ stream (out_tdata = entry,
// out_tuser = status and has_value flag, out_tlast = final result of the
// request). The stack is a chain of cells, cell 0 holding the top entry;
// push shifts the chain down, pop shifts it up, swap exchanges cells 0 and 1.
// Push, pop, peek, swap and unknown opcodes give one result in the cycle after
// acceptance, and a new request is taken every cycle the output register
// is free or being drained: throughput one request per cycle.
// Dump of n entries emits n results, one per cycle unless stalled, by rotating
// the occupied cells through the top; in_tready stays low until the last one
// is loaded, and the rotation leaves the stack as it was.
// A stall on out_tready holds the output register and stops both the chain
// and input acceptance. Reset (rst_n low, synchronous) empties the stack and
// clears the output valid; cell contents are not cleared.
`timescale 1ns / 1ps
module lifo_stack_opcode_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic signed [lsou_pkg::DATA_W-1:0] in_tdata,  // [31:0] push_value
  input  logic [lsou_pkg::OP_W-1:0]     in_tuser,       // [2:0] req_type
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic signed [lsou_pkg::DATA_W-1:0] out_tdata, // [31:0] stack_value
  output logic [lsou_pkg::STATUS_W:0]   out_tuser,      // [2:0] status, [3] has_value
  output logic                          out_tlast       // last_result
);
  import lsou_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t              state_r,   state_nxt;
  logic [CNT_W-1:0]    count_r,   count_nxt;
  logic [CNT_W-1:0]    remain_r,  remain_nxt;
  logic                out_valid_r, out_valid_nxt;
  entry_t              out_data_r,  out_data_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_has_r,   out_has_nxt;
  logic                out_last_r,  out_last_nxt;

  logic in_fire, out_free, dump_step;
  logic is_full, is_empty;
  logic push_go, pop_go, swap_go, rotate_go;

  entry_t    cell_q   [STACK_DEPTH];
  entry_t    top_d;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign dump_step = (state_r == S_DUMP) && out_free;
  assign is_full   = (count_r == CNT_W'(STACK_DEPTH));
  assign is_empty  = (count_r == '0);
  assign top_d     = cell_q[0];

  assign push_go   = in_fire && (in_tuser == OP_PUSH) && !is_full;
  assign pop_go    = in_fire && (in_tuser == OP_POP) && !is_empty;
  assign swap_go   = in_fire && (in_tuser == OP_SWAP) && (count_r >= CNT_W'(2));
  assign rotate_go = (in_fire && (in_tuser == OP_DUMP) && !is_empty) || dump_step;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      entry_t    above_d;
      entry_t    below_d;
      cell_cmd_t cell_cmd;

      if (gi == 0) begin : g_first
        assign above_d = in_tdata;
      end else begin : g_mid
        assign above_d = cell_q[gi-1];
      end

      if (gi == STACK_DEPTH - 1) begin : g_tail
        assign below_d = cell_q[gi];
      end else begin : g_inner
        assign below_d = cell_q[gi+1];
      end

      always_comb begin
        priority if (push_go) begin
          cell_cmd = CELL_FROM_ABOVE;
        end else if (pop_go) begin
          cell_cmd = CELL_FROM_BELOW;
        end else if (swap_go && gi == 0) begin
          cell_cmd = CELL_FROM_BELOW;
        end else if (swap_go && gi == 1) begin
          cell_cmd = CELL_FROM_ABOVE;
        end else if (rotate_go && (CNT_W'(gi + 1) < count_r)) begin
          cell_cmd = CELL_FROM_BELOW;
        end else if (rotate_go && (CNT_W'(gi + 1) == count_r)) begin
          // bottom occupied cell takes the entry leaving the top
          cell_cmd = CELL_FROM_WRAP;
        end else begin
          cell_cmd = CELL_HOLD;
        end
      end

      lsou_cell u_cell (
        .clk     (clk),
        .cmd     (cell_cmd),
        .above_d (above_d),
        .below_d (below_d),
        .wrap_d  (top_d),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;

    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_status_nxt = ST_OK;
      out_has_nxt    = 1'b0;
      out_last_nxt   = 1'b1;
      unique case (in_tuser)
        OP_PUSH: begin
          if (is_full) begin
            out_status_nxt = ST_PUSH_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_DUMP: begin
          if (!is_empty) begin
            out_data_nxt = top_d;
            out_has_nxt  = 1'b1;
            out_last_nxt = (count_r == CNT_W'(1));
            if (count_r != CNT_W'(1)) begin
              state_nxt  = S_DUMP;
              remain_nxt = count_r - CNT_W'(1);
            end
          end
        end
        OP_PEEK: begin
          if (is_empty) begin
            out_status_nxt = ST_PEEK_EMPTY;
          end else begin
            out_data_nxt = top_d;
            out_has_nxt  = 1'b1;
          end
        end
        OP_POP: begin
          if (is_empty) begin
            out_status_nxt = ST_POP_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_SWAP: begin
          if (!swap_go) begin
            out_status_nxt = ST_SWAP_SHORT;
          end
        end
        default: begin
        end
      endcase
    end else if (dump_step) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = top_d;
      out_status_nxt = ST_OK;
      out_has_nxt    = 1'b1;
      out_last_nxt   = (remain_r == CNT_W'(1));
      remain_nxt     = remain_r - CNT_W'(1);
      if (remain_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      remain_r     <= remain_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_has_r    <= out_has_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_has_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/lsou_cell.sv
// one stack cell: holds an entry and loads from a neighbor or the top cell
`timescale 1ns / 1ps
module lsou_cell (
  input  logic               clk,
  input  lsou_pkg::cell_cmd_t cmd,
  input  lsou_pkg::entry_t   above_d,
  input  lsou_pkg::entry_t   below_d,
  input  lsou_pkg::entry_t   wrap_d,
  output lsou_pkg::entry_t   q
);
  import lsou_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  always_comb begin
    unique case (cmd)
      CELL_FROM_ABOVE: data_nxt = above_d;
      CELL_FROM_BELOW: data_nxt = below_d;
      CELL_FROM_WRAP:  data_nxt = wrap_d;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

>>> rtl/lsou_checker.sv
// port-level checker for the lifo stack opcode unit, bound to the top level
`timescale 1ns / 1ps
module lsou_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic signed [lsou_pkg::DATA_W-1:0] out_tdata,
  input logic [lsou_pkg::STATUS_W:0]        out_tuser,
  input logic                               out_tlast
);
  import lsou_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // a result without a value carries zero data
  a_no_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[STATUS_W] |-> out_tdata == '0)
    else $error("result without value has nonzero data");

  // an error result is a single, value-free result
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[STATUS_W-1:0] != ST_OK
      |-> out_tlast && !out_tuser[STATUS_W])
    else $error("error result carries a value or is not last");

  // no new request is taken while a dump is still running
  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request accepted during dump");

  // only defined status codes appear
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[STATUS_W-1:0] == ST_OK
      || out_tuser[STATUS_W-1:0] == ST_PEEK_EMPTY
      || out_tuser[STATUS_W-1:0] == ST_POP_EMPTY
      || out_tuser[STATUS_W-1:0] == ST_SWAP_SHORT
      || out_tuser[STATUS_W-1:0] == ST_PUSH_FULL)
    else $error("undefined status code");

endmodule

bind lifo_stack_opcode_unit lsou_checker u_lsou_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
